[sv/pqrp_pkg.sv]
// Shared types, constants and pixel conversion functions of the pixel quantize RLE packer.
`default_nettype none

package pqrp_pkg;

  localparam int RUN_LIMIT_DEF   = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [2:0] FMT_RAW332    = 3'd0;
  localparam logic [2:0] FMT_RLE332    = 3'd1;
  localparam logic [2:0] FMT_PACKED444 = 3'd2;
  localparam logic [2:0] FMT_RAW565    = 3'd3;
  localparam logic [2:0] FMT_RLE565    = 3'd4;
  localparam logic [2:0] FMT_SIZE332   = 3'd5;
  localparam logic [2:0] FMT_SIZE565   = 3'd6;

  localparam logic [0:0] REG_FORMAT = 1'b0;

  typedef enum logic [1:0] {
    TR_NONE = 2'd0,
    TR_SUM  = 2'd1,
    TR_SIZE = 2'd2
  } trailer_e;

  typedef struct packed {
    logic [5:0][7:0] data;
    logic [2:0]      n_data;
    logic            summed;
    trailer_e        trailer;
    logic [2:0]      size_inc;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  c332;
    logic [11:0] c444;
    logic [15:0] c565;
    logic        last;
  } pix_t;

  function automatic logic [2:0] q3(input logic [7:0] v);
    logic [8:0] r;
    r = {1'b0, v} + 9'd16;
    q3 = r[8] ? 3'd7 : r[7:5];
  endfunction

  function automatic logic [1:0] q2(input logic [7:0] v);
    logic [8:0] r;
    r = {1'b0, v} + 9'd32;
    q2 = r[8] ? 2'd3 : r[7:6];
  endfunction

  function automatic logic [3:0] q4(input logic [7:0] v);
    logic [8:0] r;
    r = {1'b0, v} + 9'd8;
    q4 = r[8] ? 4'd15 : r[7:4];
  endfunction

  function automatic logic near20(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    near20 = (d <= 8'd20);
  endfunction

  function automatic logic [7:0] to332(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    logic [9:0]  s;
    logic [19:0] prod;
    logic [7:0]  avg;
    logic [2:0]  g3;
    s    = {2'b00, r} + {2'b00, g} + {2'b00, b};
    prod = 20'(s) * 20'd683;
    avg  = prod[18:11];
    g3   = q3(avg);
    if ((s < 10'd60) || ((r < 8'd32) && (g < 8'd32) && (b < 8'd32))) begin
      to332 = 8'h00;
    end else if ((r < 8'd120) && (g < 8'd120) && (b < 8'd120) && near20(r, g) &&
                 near20(g, b)) begin
      to332 = {g3, g3, q2(avg)};
    end else if (({1'b0, g} > ({1'b0, r} + 9'd45)) &&
                 ({1'b0, g} > ({1'b0, b} + 9'd30))) begin
      to332 = 8'h1C;
    end else begin
      to332 = {q3(r), q3(g), q2(b)};
    end
  endfunction

  function automatic logic [11:0] to444(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    to444 = {q4(r), q4(g), q4(b)};
  endfunction

  function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    to565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

[sv/pqrp_enc.sv]
// Input stage: accept pixels and register their RGB332, RGB444 and RGB565 codes.
`default_nettype none

module pqrp_enc (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    red_i,
  input  wire logic [7:0]    green_i,
  input  wire logic [7:0]    blue_i,
  input  wire logic          last_pixel_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               pix_valid_o,
  output pqrp_pkg::pix_t     pix_o,
  input  wire logic          pix_take_i
);

  logic           valid_q, valid_d;
  pqrp_pkg::pix_t pix_q;

  assign in_ready_o  = !valid_q || pix_take_i;
  assign pix_valid_o = valid_q;
  assign pix_o       = pix_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pix_q.c332 <= pqrp_pkg::to332(red_i, green_i, blue_i);
      pix_q.c444 <= pqrp_pkg::to444(red_i, green_i, blue_i);
      pix_q.c565 <= pqrp_pkg::to565(red_i, green_i, blue_i);
      pix_q.last <= last_pixel_i;
    end
  end

endmodule

`default_nettype wire

[sv/pqrp_front.sv]
// Front end: track runs and held pixels, and turn pixels into byte commands.
`default_nettype none

module pqrp_front #(
  parameter int RUN_LIMIT = pqrp_pkg::RUN_LIMIT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     format_i,
  input  wire logic           clear_i,
  input  wire logic           pix_valid_i,
  input  wire pqrp_pkg::pix_t pix_i,
  output logic                pix_take_o,
  input  wire logic           q_full_i,
  output logic                q_push_o,
  output pqrp_pkg::cmd_t      q_cmd_o
);

  logic [15:0] run_val_q, run_val_d;
  logic [7:0]  run_len_q, run_len_d;
  logic [11:0] held_q, held_d;
  logic        held_v_q, held_v_d;

  logic [15:0] v;
  logic        flush_old;
  logic [7:0]  new_len;
  logic [15:0] new_val;
  logic        last;
  pqrp_pkg::cmd_t cmd;

  assign last       = pix_i.last;
  assign pix_take_o = pix_valid_i && !q_full_i;

  always_comb begin
    v = ((format_i == pqrp_pkg::FMT_RLE332) || (format_i == pqrp_pkg::FMT_SIZE332)) ?
        {8'h00, pix_i.c332} : pix_i.c565;
    flush_old = (run_len_q != 8'd0) && ((v != run_val_q) || (run_len_q >= 8'(RUN_LIMIT)));
    if (flush_old || (run_len_q == 8'd0)) begin
      new_len = 8'd1;
      new_val = v;
    end else begin
      new_len = run_len_q + 8'd1;
      new_val = run_val_q;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.last     = last;
    cmd.trailer  = pqrp_pkg::TR_NONE;
    run_val_d    = run_val_q;
    run_len_d    = run_len_q;
    held_d       = held_q;
    held_v_d     = held_v_q;
    unique case (format_i)
      pqrp_pkg::FMT_RAW332: begin
        cmd.data[0] = pix_i.c332;
        cmd.n_data  = 3'd1;
      end
      pqrp_pkg::FMT_RLE332: begin
        run_val_d = new_val;
        run_len_d = new_len;
        if (flush_old) begin
          cmd.data[0] = run_len_q;
          cmd.data[1] = run_val_q[7:0];
          cmd.data[2] = new_len;
          cmd.data[3] = new_val[7:0];
          cmd.n_data  = last ? 3'd4 : 3'd2;
        end else begin
          cmd.data[0] = new_len;
          cmd.data[1] = new_val[7:0];
          cmd.n_data  = last ? 3'd2 : 3'd0;
        end
      end
      pqrp_pkg::FMT_RLE565: begin
        run_val_d  = new_val;
        run_len_d  = new_len;
        cmd.summed = 1'b1;
        if (flush_old) begin
          cmd.data[0] = run_len_q;
          cmd.data[1] = run_val_q[15:8];
          cmd.data[2] = run_val_q[7:0];
          cmd.data[3] = new_len;
          cmd.data[4] = new_val[15:8];
          cmd.data[5] = new_val[7:0];
          cmd.n_data  = last ? 3'd6 : 3'd3;
        end else begin
          cmd.data[0] = new_len;
          cmd.data[1] = new_val[15:8];
          cmd.data[2] = new_val[7:0];
          cmd.n_data  = last ? 3'd3 : 3'd0;
        end
      end
      pqrp_pkg::FMT_SIZE332: begin
        run_val_d    = new_val;
        run_len_d    = new_len;
        cmd.size_inc = (flush_old ? 3'd2 : 3'd0) + (last ? 3'd2 : 3'd0);
      end
      pqrp_pkg::FMT_SIZE565: begin
        run_val_d    = new_val;
        run_len_d    = new_len;
        cmd.size_inc = (flush_old ? 3'd3 : 3'd0) + (last ? 3'd3 : 3'd0);
      end
      pqrp_pkg::FMT_PACKED444: begin
        if (held_v_q) begin
          cmd.data[0] = held_q[11:4];
          cmd.data[1] = {held_q[3:0], pix_i.c444[11:8]};
          cmd.data[2] = pix_i.c444[7:0];
          cmd.n_data  = 3'd3;
          held_v_d    = 1'b0;
        end else if (last) begin
          cmd.data[0] = pix_i.c444[11:4];
          cmd.data[1] = {pix_i.c444[3:0], 4'h0};
          cmd.n_data  = 3'd2;
        end else begin
          held_d   = pix_i.c444;
          held_v_d = 1'b1;
        end
      end
      pqrp_pkg::FMT_RAW565: begin
        cmd.data[0] = pix_i.c565[7:0];
        cmd.data[1] = pix_i.c565[15:8];
        cmd.n_data  = 3'd2;
        cmd.summed  = 1'b1;
      end
      default: begin
      end
    endcase
    if (last) begin
      if ((format_i == pqrp_pkg::FMT_RAW565) || (format_i == pqrp_pkg::FMT_RLE565)) begin
        cmd.trailer = pqrp_pkg::TR_SUM;
      end else if ((format_i == pqrp_pkg::FMT_SIZE332) ||
                   (format_i == pqrp_pkg::FMT_SIZE565)) begin
        cmd.trailer = pqrp_pkg::TR_SIZE;
      end
      run_val_d = '0;
      run_len_d = '0;
      held_d    = '0;
      held_v_d  = 1'b0;
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = pix_take_o && ((cmd.n_data != 3'd0) || last || (cmd.size_inc != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_val_q <= '0;
      run_len_q <= '0;
      held_q    <= '0;
      held_v_q  <= 1'b0;
    end else if (clear_i) begin
      run_val_q <= '0;
      run_len_q <= '0;
      held_q    <= '0;
      held_v_q  <= 1'b0;
    end else if (pix_take_o) begin
      run_val_q <= run_val_d;
      run_len_q <= run_len_d;
      held_q    <= held_d;
      held_v_q  <= held_v_d;
    end
  end

endmodule

`default_nettype wire

[sv/pqrp_queue.sv]
// Command queue between the front end and the byte serializer.
`default_nettype none

module pqrp_queue #(
  parameter int DEPTH = pqrp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pqrp_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                nonempty_o,
  output pqrp_pkg::cmd_t      cmd_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pqrp_pkg::cmd_t mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CW'(DEPTH));
  assign nonempty_o = (count_q != '0);
  assign cmd_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[sv/pqrp_back.sv]
// Back end: serialize command bytes, keep byte sum and size count, append trailers.
`default_nettype none

module pqrp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           q_nonempty_i,
  input  wire pqrp_pkg::cmd_t q_cmd_i,
  output logic                q_pop_o,
  output logic [7:0]          out_byte_o,
  output logic                end_of_area_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i
);

  logic [2:0]  idx_q, idx_d;
  logic [15:0] sum_q, sum_d;
  logic [31:0] size_q, size_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q;
  logic        oend_q;

  logic [3:0]  total;
  logic [2:0]  tidx;
  logic [32:0] size_add;
  logic [31:0] size_eff;
  logic        is_data;
  logic [7:0]  dbyte;
  logic [7:0]  tbyte;
  logic [7:0]  byte_sel;
  logic        can_load;
  logic        load;
  logic        final_byte;

  assign out_byte_o    = obyte_q;
  assign end_of_area_o = oend_q;
  assign out_valid_o   = ovalid_q;

  always_comb begin
    unique case (q_cmd_i.trailer)
      pqrp_pkg::TR_SUM:  total = {1'b0, q_cmd_i.n_data} + 4'd2;
      pqrp_pkg::TR_SIZE: total = {1'b0, q_cmd_i.n_data} + 4'd4;
      default:           total = {1'b0, q_cmd_i.n_data};
    endcase
    size_add = {1'b0, size_q} + {30'd0, q_cmd_i.size_inc};
    size_eff = size_add[32] ? 32'hFFFF_FFFF : size_add[31:0];
    tidx     = idx_q - q_cmd_i.n_data;
    is_data  = (idx_q < q_cmd_i.n_data);
    case (idx_q)
      3'd0:    dbyte = q_cmd_i.data[0];
      3'd1:    dbyte = q_cmd_i.data[1];
      3'd2:    dbyte = q_cmd_i.data[2];
      3'd3:    dbyte = q_cmd_i.data[3];
      3'd4:    dbyte = q_cmd_i.data[4];
      3'd5:    dbyte = q_cmd_i.data[5];
      default: dbyte = 8'h00;
    endcase
    if (q_cmd_i.trailer == pqrp_pkg::TR_SUM) begin
      tbyte = tidx[0] ? sum_q[15:8] : sum_q[7:0];
    end else begin
      case (tidx[1:0])
        2'd0:    tbyte = size_eff[7:0];
        2'd1:    tbyte = size_eff[15:8];
        2'd2:    tbyte = size_eff[23:16];
        default: tbyte = size_eff[31:24];
      endcase
    end
    byte_sel = is_data ? dbyte : tbyte;
  end

  assign can_load   = !ovalid_q || out_ready_i;
  assign load       = q_nonempty_i && (total != 4'd0) && can_load;
  assign final_byte = ({1'b0, idx_q} == (total - 4'd1));
  assign q_pop_o    = q_nonempty_i && ((total == 4'd0) || (can_load && final_byte));

  always_comb begin
    idx_d    = idx_q;
    sum_d    = sum_q;
    size_d   = size_q;
    ovalid_d = ovalid_q;
    if (can_load) begin
      ovalid_d = load;
    end
    if (load) begin
      idx_d = final_byte ? 3'd0 : idx_q + 3'd1;
      if (is_data && q_cmd_i.summed) begin
        sum_d = sum_q + {8'h00, dbyte};
      end
    end
    if (q_pop_o) begin
      size_d = size_eff;
      if (q_cmd_i.last) begin
        sum_d  = '0;
        size_d = '0;
      end
    end
    if (clear_i) begin
      sum_d  = '0;
      size_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      sum_q    <= '0;
      size_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      size_q   <= size_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= byte_sel;
      oend_q  <= q_cmd_i.last && final_byte;
    end
  end

endmodule

`default_nettype wire

[sv/pixel_quantize_rle_packer.sv]
// Top level of the pixel quantize RLE packer: format register, front end, queue, back end.
// A pixel passes the encoder register, the command queue and the output byte register.
// Throughput: one output byte per cycle while out_ready_i is high; a pixel has up to
//   three bytes (rle565 with changing pixels), and the final pixel of an area up to
//   eight (two runs in rle565 plus the byte sum); a four-entry queue absorbs the rest.
// Reset: clears run, held pixel, byte sum, size count and queue; format resets to packed444.
`default_nettype none

module pixel_quantize_rle_packer #(
  parameter int RUN_LIMIT   = pqrp_pkg::RUN_LIMIT_DEF,
  parameter int QUEUE_DEPTH = pqrp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic        last_pixel_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic [7:0]       out_byte_o,
  output logic             end_of_area_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  logic [2:0]     format_q;
  logic           cfg_wr;
  logic           pix_valid;
  pqrp_pkg::pix_t pix;
  logic           pix_take;
  logic           q_full;
  logic           q_push;
  pqrp_pkg::cmd_t q_cmd_in;
  logic           q_nonempty;
  logic           q_pop;
  pqrp_pkg::cmd_t q_cmd_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pqrp_pkg::REG_FORMAT);
  assign prdata = (paddr[2] == pqrp_pkg::REG_FORMAT) ? {29'd0, format_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= pqrp_pkg::FMT_PACKED444;
    end else if (cfg_wr) begin
      format_q <= pwdata[2:0];
    end
  end

  pqrp_enc u_enc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix),
    .pix_take_i   (pix_take)
  );

  pqrp_front #(
    .RUN_LIMIT (RUN_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .format_i    (format_q),
    .clear_i     (cfg_wr),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .pix_take_o  (pix_take),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  pqrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .cmd_i      (q_cmd_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .cmd_o      (q_cmd_out)
  );

  pqrp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_wr),
    .q_nonempty_i  (q_nonempty),
    .q_cmd_i       (q_cmd_out),
    .q_pop_o       (q_pop),
    .out_byte_o    (out_byte_o),
    .end_of_area_o (end_of_area_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

`default_nettype wire
